FILE: hw/rtl/chsr_pkg.sv
// Package: shared types, constants, hash step functions and a BCD increment helper for the shard router.
`timescale 1ns / 1ps
`default_nettype none
package chsr_pkg;

   localparam int unsigned MAX_SHARDS_DEFAULT = 16;
   localparam int unsigned VNODES_DEFAULT     = 32;

   localparam logic [31:0] FNV_INIT  = 32'd2166136261;
   localparam logic [15:0] CRC_INIT  = 16'h0000;
   localparam logic [15:0] CRC_POLY  = 16'h1021;

   localparam logic [1:0] MODE_KEY     = 2'd0;
   localparam logic [1:0] MODE_END     = 2'd1;
   localparam logic [1:0] MODE_REBUILD = 2'd2;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_V    = 8'h56;
   localparam logic [7:0] CHAR_N    = 8'h4E;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] key_byte;
   } req_type;

   typedef struct packed {
      logic [3:0] dest_shard;
      logic       used_fallback;
   } rsp_type;

   // prime 16777619 = 2^24 + 403
   function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] x;
      x = h ^ {24'd0, b};
      return (x << 24) + (x * 32'd403);
   endfunction

   function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'd0};
      for (int k = 0; k < 8; k++) begin
         r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      end
      return r;
   endfunction

   // three decimal digits, units in the low nibble
   function automatic logic [11:0] bcd_inc(input logic [11:0] d);
      logic [11:0] r;
      r = d;
      if (d[3:0] != 4'd9) begin
         r[3:0] = d[3:0] + 4'd1;
      end else begin
         r[3:0] = 4'd0;
         if (d[7:4] != 4'd9) begin
            r[7:4] = d[7:4] + 4'd1;
         end else begin
            r[7:4]  = 4'd0;
            r[11:8] = d[11:8] + 4'd1;
         end
      end
      return r;
   endfunction

   // hash of "SHARD-"
   localparam logic [31:0] SHARD_PREFIX_HASH =
      fnv_step(fnv_step(fnv_step(fnv_step(fnv_step(fnv_step(FNV_INIT,
         8'h53), 8'h48), 8'h41), 8'h52), 8'h44), 8'h2D);

endpackage
`default_nettype wire

FILE: hw/rtl/chsr_hash_unit.sv
// Shared hash step: one FNV-1a byte step and one CRC-16 byte step.
`timescale 1ns / 1ps
`default_nettype none
module chsr_hash_unit (
   input  wire logic [31:0] fnv_src,
   input  wire logic [15:0] crc_src,
   input  wire logic [7:0]  byte_in,
   output logic      [31:0] fnv_out,
   output logic      [15:0] crc_out
);
   import chsr_pkg::*;

   assign fnv_out = fnv_step(fnv_src, byte_in);
   assign crc_out = crc_step(crc_src, byte_in);

endmodule
`default_nettype wire

FILE: hw/rtl/consistent_hash_shard_router_unit.sv
// Top level: consistent hash shard router with ring memory and sequencer.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------
//  request  | start / busy            | req_data (mode, key_byte)
//  result   | rsp_valid (1-cycle)     | rsp_data (dest_shard, used_fallback)
//  config   | csr_valid / csr_ready   | csr_data (shard count)
//
// Key byte: hashed while idle. End of key: a zero result with no shards, a
// bit-serial CRC remainder on an empty ring, else a scan of the ring memory.
// Rebuild: per vnode, byte hashing and a collision scan via the single ring
// read port. Synchronous reset; ring memory is not cleared, the fill count
// marks validity. Results are a one-cycle strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module consistent_hash_shard_router_unit #(
   parameter int unsigned MAX_SHARDS       = chsr_pkg::MAX_SHARDS_DEFAULT,
   parameter int unsigned VNODES_PER_SHARD = chsr_pkg::VNODES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire chsr_pkg::req_type req_data,
   output logic                  rsp_valid,
   output chsr_pkg::rsp_type     rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [4:0]       csr_data
);
   import chsr_pkg::*;

   localparam int unsigned DEPTH  = MAX_SHARDS * VNODES_PER_SHARD;
   localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(DEPTH + 1);
   localparam int unsigned OWN_W  = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
   localparam int unsigned V_W    = (VNODES_PER_SHARD > 1) ? $clog2(VNODES_PER_SHARD) : 1;
   localparam int unsigned ENT_W  = 32 + OWN_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SH_TXT, ST_VN_TXT, ST_INSERT, ST_LOOKUP, ST_DIVIDE
   } state_type;

   state_type          state_ff, state_in;
   logic [4:0]         num_ff, num_in;
   logic [31:0]        fnv_ff, fnv_in;
   logic [15:0]        crc_ff, crc_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  iss_ff, iss_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [31:0]        pfx_ff, pfx_in;
   logic [31:0]        key_ff, key_in;
   logic [2:0]         pos_ff, pos_in;
   logic [4:0]         s_ff, s_in;
   logic [V_W-1:0]     v_ff, v_in;
   logic [11:0]        sbcd_ff, sbcd_in;
   logic [11:0]        vbcd_ff, vbcd_in;
   logic               best_vld_ff, best_vld_in;
   logic [31:0]        best_hash_ff, best_hash_in;
   logic [OWN_W-1:0]   best_own_ff, best_own_in;
   logic               low_vld_ff, low_vld_in;
   logic [31:0]        low_hash_ff, low_hash_in;
   logic [OWN_W-1:0]   low_own_ff, low_own_in;
   logic [15:0]        div_ff, div_in;
   logic [4:0]         rem_ff, rem_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               rsp_vld_ff, rsp_vld_in;
   rsp_type            rsp_ff, rsp_in;

   logic [ENT_W-1:0]   ring_mem [DEPTH];
   logic [ENT_W-1:0]   rd_q_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENT_W-1:0]   wr_data;

   logic [31:0]        fnv_src, fnv_out;
   logic [15:0]        crc_out;
   logic [7:0]         byte_sel;
   logic               byte_ok;
   logic [31:0]        rd_hash;
   logic [OWN_W-1:0]   rd_own;
   logic [5:0]         div_t;
   logic [4:0]         rem_nxt;
   logic               match;
   logic               ins_done;

   chsr_hash_unit u_hash (
      .fnv_src (fnv_src),
      .crc_src (crc_ff),
      .byte_in (byte_sel),
      .fnv_out (fnv_out),
      .crc_out (crc_out)
   );

   assign rd_hash   = rd_q_ff[31:0];
   assign rd_own    = rd_q_ff[ENT_W-1:32];
   assign rd_addr   = iss_ff[IDX_W-1:0];
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;
   assign match     = cmp_vld_ff && (rd_hash == key_ff);
   assign div_t     = {rem_ff, div_ff[15]};
   assign rem_nxt   = (div_t >= {1'b0, num_ff}) ? 5'(div_t - {1'b0, num_ff}) : div_t[4:0];

   always_comb begin
      fnv_src  = fnv_ff;
      byte_sel = req_data.key_byte;
      byte_ok  = 1'b1;
      unique case (state_ff)
         ST_SH_TXT: begin
            fnv_src = pfx_ff;
            unique case (pos_ff)
               3'd0: begin
                  byte_sel = CHAR_ZERO + {4'd0, sbcd_ff[11:8]};
                  byte_ok  = (sbcd_ff[11:8] != 4'd0);
               end
               3'd1: begin
                  byte_sel = CHAR_ZERO + {4'd0, sbcd_ff[7:4]};
                  byte_ok  = (sbcd_ff[11:4] != 8'd0);
               end
               3'd2: byte_sel = CHAR_ZERO + {4'd0, sbcd_ff[3:0]};
               3'd4: byte_sel = CHAR_V;
               3'd5: byte_sel = CHAR_N;
               default: byte_sel = CHAR_DASH;
            endcase
         end
         ST_VN_TXT: begin
            fnv_src = key_ff;
            unique case (pos_ff)
               3'd0: begin
                  byte_sel = CHAR_ZERO + {4'd0, vbcd_ff[11:8]};
                  byte_ok  = (vbcd_ff[11:8] != 4'd0);
               end
               3'd1: begin
                  byte_sel = CHAR_ZERO + {4'd0, vbcd_ff[7:4]};
                  byte_ok  = (vbcd_ff[11:4] != 8'd0);
               end
               default: byte_sel = CHAR_ZERO + {4'd0, vbcd_ff[3:0]};
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      fnv_in       = fnv_ff;
      crc_in       = crc_ff;
      fill_in      = fill_ff;
      iss_in       = iss_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_vld_in   = cmp_vld_ff;
      pfx_in       = pfx_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      s_in         = s_ff;
      v_in         = v_ff;
      sbcd_in      = sbcd_ff;
      vbcd_in      = vbcd_ff;
      best_vld_in  = best_vld_ff;
      best_hash_in = best_hash_ff;
      best_own_in  = best_own_ff;
      low_vld_in   = low_vld_ff;
      low_hash_in  = low_hash_ff;
      low_own_in   = low_own_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_vld_in   = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = cmp_idx_ff;
      wr_data      = {OWN_W'(s_ff), key_ff};
      ins_done     = 1'b0;

      if (csr_valid && csr_ready) begin
         num_in = ({4'd0, csr_data} > 9'(MAX_SHARDS)) ? 5'(MAX_SHARDS) : csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.mode)
                  MODE_KEY: begin
                     fnv_in = fnv_out;
                     crc_in = crc_out;
                  end
                  MODE_END: begin
                     fnv_in = FNV_INIT;
                     crc_in = CRC_INIT;
                     if (num_ff == 5'd0) begin
                        rsp_vld_in = 1'b1;
                        rsp_in     = '0;
                     end else if (fill_ff == '0) begin
                        div_in   = crc_ff;
                        rem_in   = 5'd0;
                        cnt_in   = 4'd0;
                        state_in = ST_DIVIDE;
                     end else begin
                        key_in      = fnv_ff;
                        iss_in      = '0;
                        cmp_vld_in  = 1'b0;
                        best_vld_in = 1'b0;
                        low_vld_in  = 1'b0;
                        state_in    = ST_LOOKUP;
                     end
                  end
                  MODE_REBUILD: begin
                     if (num_ff != 5'd0) begin
                        fill_in  = '0;
                        s_in     = 5'd0;
                        v_in     = '0;
                        sbcd_in  = 12'd0;
                        vbcd_in  = 12'd0;
                        pfx_in   = SHARD_PREFIX_HASH;
                        pos_in   = 3'd0;
                        state_in = ST_SH_TXT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SH_TXT: begin
            if (byte_ok) begin
               pfx_in = fnv_out;
            end
            if (pos_ff == 3'd6) begin
               key_in   = fnv_out;
               pos_in   = 3'd0;
               state_in = ST_VN_TXT;
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end
         ST_VN_TXT: begin
            if (byte_ok) begin
               key_in = fnv_out;
            end
            if (pos_ff == 3'd2) begin
               iss_in     = '0;
               cmp_vld_in = 1'b0;
               state_in   = ST_INSERT;
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end
         ST_INSERT: begin
            if (match) begin
               wr_en    = 1'b1;
               ins_done = 1'b1;
            end else if (iss_ff != fill_ff) begin
               iss_in     = iss_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = iss_ff[IDX_W-1:0];
            end else if (cmp_vld_ff) begin
               cmp_vld_in = 1'b0;
            end else begin
               if (fill_ff != FILL_W'(DEPTH)) begin
                  wr_en   = 1'b1;
                  wr_addr = fill_ff[IDX_W-1:0];
                  fill_in = fill_ff + 1'b1;
               end
               ins_done = 1'b1;
            end
            if (ins_done) begin
               cmp_vld_in = 1'b0;
               pos_in     = 3'd0;
               if (v_ff == V_W'(VNODES_PER_SHARD - 1)) begin
                  if (s_ff == num_ff - 5'd1) begin
                     state_in = ST_IDLE;
                  end else begin
                     s_in     = s_ff + 5'd1;
                     sbcd_in  = bcd_inc(sbcd_ff);
                     v_in     = '0;
                     vbcd_in  = 12'd0;
                     pfx_in   = SHARD_PREFIX_HASH;
                     state_in = ST_SH_TXT;
                  end
               end else begin
                  v_in     = v_ff + 1'b1;
                  vbcd_in  = bcd_inc(vbcd_ff);
                  key_in   = pfx_ff;
                  state_in = ST_VN_TXT;
               end
            end
         end
         ST_LOOKUP: begin
            if (cmp_vld_ff) begin
               if (!low_vld_ff || (rd_hash < low_hash_ff)) begin
                  low_vld_in  = 1'b1;
                  low_hash_in = rd_hash;
                  low_own_in  = rd_own;
               end
               if ((rd_hash >= key_ff) && (!best_vld_ff || (rd_hash < best_hash_ff))) begin
                  best_vld_in  = 1'b1;
                  best_hash_in = rd_hash;
                  best_own_in  = rd_own;
               end
            end
            if (iss_ff != fill_ff) begin
               iss_in     = iss_ff + 1'b1;
               cmp_vld_in = 1'b1;
            end else if (cmp_vld_ff) begin
               cmp_vld_in = 1'b0;
            end else begin
               rsp_vld_in           = 1'b1;
               rsp_in.dest_shard    = best_vld_ff ? 4'(best_own_ff) : 4'(low_own_ff);
               rsp_in.used_fallback = 1'b0;
               state_in             = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            rem_in = rem_nxt;
            div_in = div_ff << 1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               rsp_vld_in           = 1'b1;
               rsp_in.dest_shard    = rem_nxt[3:0];
               rsp_in.used_fallback = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         num_ff     <= 5'd1;
         fnv_ff     <= FNV_INIT;
         crc_ff     <= CRC_INIT;
         fill_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         num_ff     <= num_in;
         fnv_ff     <= fnv_in;
         crc_ff     <= crc_in;
         fill_ff    <= fill_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      iss_ff       <= iss_in;
      cmp_idx_ff   <= cmp_idx_in;
      pfx_ff       <= pfx_in;
      key_ff       <= key_in;
      pos_ff       <= pos_in;
      s_ff         <= s_in;
      v_ff         <= v_in;
      sbcd_ff      <= sbcd_in;
      vbcd_ff      <= vbcd_in;
      best_vld_ff  <= best_vld_in;
      best_hash_ff <= best_hash_in;
      best_own_ff  <= best_own_in;
      low_vld_ff   <= low_vld_in;
      low_hash_ff  <= low_hash_in;
      low_own_ff   <= low_own_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= ring_mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the consistent hash shard router: queued requests, self-checking predictor.
`timescale 1ns / 1ps
module tb_top;
   import chsr_pkg::*;

   localparam int RING_SLOTS = 512;
   localparam int VNODES     = 32;
   localparam int IDLE_LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_type      req_data = '0;
   logic         rsp_valid;
   rsp_type      rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [4:0]   csr_data = '0;

   req_type      pending_reqs[$];
   rsp_type      expected_shards[$];
   bit           failed = 0;
   int           gap_left = 0;
   int           burst_left = 0;
   int           idle_cycles = 0;
   bit           next_start;

   // predictor state
   logic [31:0]  ring_hash[RING_SLOTS];
   logic [3:0]   ring_own[RING_SLOTS];
   int           ring_count = 0;
   logic [31:0]  key_fnv = FNV_INIT;
   logic [15:0]  key_crc = CRC_INIT;
   logic [4:0]   shards_in_use = 5'd1;

   consistent_hash_shard_router_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
      return (h ^ {24'd0, b}) * 32'd16777619;
   endfunction

   function automatic logic [15:0] crc_mix(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'd0};
      for (int k = 0; k < 8; k++) begin
         r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
      end
      return r;
   endfunction

   function automatic logic [31:0] fnv_number(input logic [31:0] h, input int n);
      if (n >= 10) begin
         h = fnv_mix(h, 8'h30 + 8'(n / 10));
      end
      return fnv_mix(h, 8'h30 + 8'(n % 10));
   endfunction

   function automatic void rebuild_ring();
      logic [31:0] h;
      bit          hit;
      if (shards_in_use == 0) return;
      ring_count = 0;
      for (int s = 0; s < shards_in_use; s++) begin
         for (int v = 0; v < VNODES; v++) begin
            h = FNV_INIT;
            h = fnv_mix(h, "S"); h = fnv_mix(h, "H"); h = fnv_mix(h, "A");
            h = fnv_mix(h, "R"); h = fnv_mix(h, "D"); h = fnv_mix(h, "-");
            h = fnv_number(h, s);
            h = fnv_mix(h, "-"); h = fnv_mix(h, "V"); h = fnv_mix(h, "N");
            h = fnv_mix(h, "-");
            h = fnv_number(h, v);
            hit = 0;
            for (int i = 0; i < ring_count; i++) begin
               if (!hit && ring_hash[i] == h) begin
                  ring_own[i] = 4'(s);
                  hit = 1;
               end
            end
            if (!hit && ring_count < RING_SLOTS) begin
               ring_hash[ring_count] = h;
               ring_own[ring_count] = 4'(s);
               ring_count++;
            end
         end
      end
   endfunction

   function automatic void route_request(input req_type r);
      rsp_type e;
      int      low, best;
      bit      found;
      case (r.mode)
         MODE_KEY: begin
            key_fnv = fnv_mix(key_fnv, r.key_byte);
            key_crc = crc_mix(key_crc, r.key_byte);
         end
         MODE_REBUILD: rebuild_ring();
         MODE_END: begin
            e = '0;
            if (shards_in_use != 0) begin
               if (ring_count == 0) begin
                  e.dest_shard = 4'(key_crc % shards_in_use);
                  e.used_fallback = 1'b1;
               end else begin
                  low = 0; best = 0; found = 0;
                  for (int i = 1; i < ring_count; i++)
                     if (ring_hash[i] < ring_hash[low]) low = i;
                  for (int i = 0; i < ring_count; i++) begin
                     if (ring_hash[i] >= key_fnv && (!found || ring_hash[i] < ring_hash[best])) begin
                        best = i;
                        found = 1;
                     end
                  end
                  e.dest_shard = found ? ring_own[best] : ring_own[low];
               end
            end
            key_fnv = FNV_INIT;
            key_crc = CRC_INIT;
            expected_shards.push_back(e);
         end
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else begin
         if (start) begin
            route_request(pending_reqs.pop_front());
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         next_start = (gap_left == 0) && (pending_reqs.size() > 0);
         if (gap_left > 0) gap_left--;
         start <= next_start;
         if (next_start) req_data <= pending_reqs[0];
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_shards.size() == 0) begin
            $display("%0t: unexpected result dest_shard=%0d used_fallback=%0d",
                     $time, rsp_data.dest_shard, rsp_data.used_fallback);
            failed = 1;
         end else begin
            if (rsp_data.dest_shard !== expected_shards[0].dest_shard) begin
               $display("%0t: dest_shard expected %0d actual %0d", $time,
                        expected_shards[0].dest_shard, rsp_data.dest_shard);
               failed = 1;
            end
            if (rsp_data.used_fallback !== expected_shards[0].used_fallback) begin
               $display("%0t: used_fallback expected %0d actual %0d", $time,
                        expected_shards[0].used_fallback, rsp_data.used_fallback);
               failed = 1;
            end
            void'(expected_shards.pop_front());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic push_req(input logic [1:0] m, input logic [7:0] b);
      req_type r;
      r.mode = m;
      r.key_byte = b;
      pending_reqs.push_back(r);
   endtask

   task automatic push_key(input int len);
      for (int i = 0; i < len; i++) push_req(MODE_KEY, 8'($urandom_range(0, 255)));
      push_req(MODE_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_reqs.size() != 0 || start || expected_shards.size() != 0 || busy)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_shards(input logic [4:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shards_in_use = (v > 5'd16) ? 5'd16 : v;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly well-formed keys; some stray ends, mode 3 noise, rare rebuilds
   task automatic random_traffic(input int n, input int rebuild_odds);
      int done, pick, len;
      done = 0;
      while (done < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6);
            push_key(len);
            done += len + 1;
         end else if (pick < 92) begin
            push_req(2'd3, 8'($urandom_range(0, 255)));
         end else if (pick < 92 + rebuild_odds) begin
            push_req(MODE_REBUILD, 8'($urandom_range(0, 255)));
            done++;
         end else begin
            push_req(MODE_END, 8'($urandom_range(0, 255)));
            done++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty ring, one shard: fallback path
      push_req(MODE_END, 8'h00);
      push_req(MODE_KEY, 8'h00);
      push_req(MODE_KEY, 8'hFF);
      push_req(MODE_END, 8'hFF);
      push_req(2'd3, 8'hA5);
      push_req(MODE_KEY, 8'h61);
      push_req(MODE_END, 8'h00);
      write_shards(5'd3);
      push_key(3);
      push_key(0);
      push_req(MODE_KEY, 8'hFF);
      push_req(MODE_END, 8'h00);
      // zero shards: no ring, rebuild ignored
      write_shards(5'd0);
      push_key(2);
      push_req(MODE_REBUILD, 8'h00);
      push_key(1);
      write_shards(5'd3);
      push_key(2);
      push_req(MODE_REBUILD, 8'h00);
      push_key(0);
      push_key(4);
      random_traffic(250, 1);
      // stale ring larger than the shard count
      write_shards(5'd1);
      random_traffic(120, 0);
      // full capacity, saturated write
      write_shards(5'd31);
      push_req(MODE_REBUILD, 8'h00);
      random_traffic(150, 0);
      write_shards(5'd17);
      random_traffic(60, 0);
      write_shards(5'd2);
      push_req(MODE_REBUILD, 8'h00);
      random_traffic(300, 3);
      write_shards(5'd0);
      random_traffic(150, 3);
      write_shards(5'd5);
      random_traffic(200, 1);
      write_shards(5'd4);
      push_req(MODE_REBUILD, 8'h00);
      random_traffic(200, 2);

      drain();
      repeat (600) @(posedge clock);
      if (!failed && expected_shards.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
